@@ rtl/avcc_pkg.sv @@
// Shared types and constants for the length-prefixed to start-code converter.
// No dependencies; used by avcc_parse, avcc_burst and the top level.
package avcc_pkg;

  localparam int unsigned START_CODE_BYTES = 4;
  localparam int unsigned LEN_W            = 32;
  localparam int unsigned CNT_W            = 3;

  localparam logic [4:0] NAL_TYPE_SPS = 5'd7;
  localparam logic [4:0] NAL_TYPE_PPS = 5'd8;
  localparam logic [4:0] NAL_TYPE_EOS = 5'd11;

  localparam logic [2:0] LSIZE_MIN   = 3'd1;
  localparam logic [2:0] LSIZE_MAX   = 3'd4;
  localparam logic [2:0] LSIZE_RESET = 3'd4;

  localparam logic [7:0] SC_ZERO_BYTE = 8'h00;
  localparam logic [7:0] SC_LAST_BYTE = 8'h01;

  localparam logic KIND_STREAM = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TRUNCATED = 2'd1,
    STATUS_EOS_NAL   = 2'd2,
    STATUS_MISMATCH  = 2'd3
  } status_e;

  // Everything one input byte causes, expanded into results by avcc_burst.
  typedef struct packed {
    logic       start_code;  // four start code bytes
    logic       payload;     // one copied payload byte
    logic       report;      // end-of-buffer report appended
    logic [7:0] data;
    logic       nal_header;
    logic [4:0] unit_type;
    logic       has_param_sets;
    status_e    status;
  } burst_desc_t;

  // One result item as it leaves the block.
  typedef struct packed {
    logic       kind;
    logic [7:0] out_byte;
    logic       nal_header;
    logic [4:0] unit_type;
    logic       has_param_sets;
    status_e    status;
    logic       last;
  } result_t;

endpackage

@@ rtl/avcc_parse.sv @@
// Stream parser: length prefix accumulation, payload countdown, SPS/PPS tracking.
// Depends on avcc_pkg. Produces at most one burst descriptor per accepted byte.
module avcc_parse (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  length_size_we_i,
  input  logic [2:0]            length_size_i,
  input  logic                  fire_i,
  input  logic [7:0]            in_byte_i,
  input  logic                  buffer_end_i,
  output avcc_pkg::burst_desc_t desc_o,
  output logic                  desc_valid_o
);

  logic [2:0]                     lsize_q;
  logic                           in_payload_q, in_payload_d;
  logic [avcc_pkg::CNT_W-1:0]     prefix_count_q, prefix_count_d;
  logic [avcc_pkg::LEN_W-1:0]     length_accum_q, length_accum_d;
  logic [avcc_pkg::LEN_W-1:0]     bytes_left_q, bytes_left_d;
  logic                           header_pending_q, header_pending_d;
  logic                           seen_sps_q, seen_sps_d;
  logic                           seen_pps_q, seen_pps_d;
  avcc_pkg::status_e              sticky_q, sticky_d;

  logic [2:0]                     lsize;
  logic [avcc_pkg::CNT_W-1:0]     pc_inc;
  logic [avcc_pkg::LEN_W-1:0]     accum_next;
  logic [avcc_pkg::LEN_W-1:0]     left_dec;
  logic [4:0]                     type_now;

  always_comb begin
    if (lsize_q < avcc_pkg::LSIZE_MIN) begin
      lsize = avcc_pkg::LSIZE_MIN;
    end else if (lsize_q > avcc_pkg::LSIZE_MAX) begin
      lsize = avcc_pkg::LSIZE_MAX;
    end else begin
      lsize = lsize_q;
    end
  end

  assign pc_inc     = prefix_count_q + avcc_pkg::CNT_W'(1);
  assign accum_next = {length_accum_q[avcc_pkg::LEN_W-9:0], in_byte_i};
  assign left_dec   = bytes_left_q - avcc_pkg::LEN_W'(1);
  assign type_now   = in_byte_i[4:0];

  always_comb begin
    in_payload_d     = in_payload_q;
    prefix_count_d   = prefix_count_q;
    length_accum_d   = length_accum_q;
    bytes_left_d     = bytes_left_q;
    header_pending_d = header_pending_q;
    seen_sps_d       = seen_sps_q;
    seen_pps_d       = seen_pps_q;
    sticky_d         = sticky_q;

    desc_o                = '0;
    desc_o.status         = avcc_pkg::STATUS_OK;

    if (in_payload_q) begin
      desc_o.payload    = 1'b1;
      desc_o.data       = in_byte_i;
      desc_o.nal_header = header_pending_q;
      if (header_pending_q) begin
        desc_o.unit_type = type_now;
        if (type_now == avcc_pkg::NAL_TYPE_SPS) seen_sps_d = 1'b1;
        if (type_now == avcc_pkg::NAL_TYPE_PPS) seen_pps_d = 1'b1;
        if (type_now == avcc_pkg::NAL_TYPE_EOS && sticky_q == avcc_pkg::STATUS_OK) begin
          sticky_d = avcc_pkg::STATUS_EOS_NAL;
        end
        header_pending_d = 1'b0;
      end
      bytes_left_d = left_dec;
      if (left_dec == '0) in_payload_d = 1'b0;
    end else begin
      length_accum_d = accum_next;
      prefix_count_d = pc_inc;
      if (pc_inc >= lsize) begin
        desc_o.start_code = 1'b1;
        if (accum_next != '0) begin
          in_payload_d     = 1'b1;
          bytes_left_d     = accum_next;
          header_pending_d = 1'b1;
        end
        length_accum_d = '0;
        prefix_count_d = '0;
      end
    end

    if (buffer_end_i) begin
      desc_o.report         = 1'b1;
      desc_o.has_param_sets = seen_sps_d & seen_pps_d;
      if (sticky_d != avcc_pkg::STATUS_OK) begin
        desc_o.status = sticky_d;
      end else if (in_payload_d || prefix_count_d != '0) begin
        desc_o.status = avcc_pkg::STATUS_TRUNCATED;
      end else if (seen_sps_d != seen_pps_d) begin
        desc_o.status = avcc_pkg::STATUS_MISMATCH;
      end
      // clear stream state for the next buffer
      in_payload_d     = 1'b0;
      prefix_count_d   = '0;
      length_accum_d   = '0;
      bytes_left_d     = '0;
      header_pending_d = 1'b0;
      seen_sps_d       = 1'b0;
      seen_pps_d       = 1'b0;
      sticky_d         = avcc_pkg::STATUS_OK;
    end
  end

  assign desc_valid_o = desc_o.start_code | desc_o.payload | desc_o.report;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lsize_q          <= avcc_pkg::LSIZE_RESET;
      in_payload_q     <= 1'b0;
      prefix_count_q   <= '0;
      length_accum_q   <= '0;
      bytes_left_q     <= '0;
      header_pending_q <= 1'b0;
      seen_sps_q       <= 1'b0;
      seen_pps_q       <= 1'b0;
      sticky_q         <= avcc_pkg::STATUS_OK;
    end else begin
      if (length_size_we_i) lsize_q <= length_size_i;
      if (fire_i) begin
        in_payload_q     <= in_payload_d;
        prefix_count_q   <= prefix_count_d;
        length_accum_q   <= length_accum_d;
        bytes_left_q     <= bytes_left_d;
        header_pending_q <= header_pending_d;
        seen_sps_q       <= seen_sps_d;
        seen_pps_q       <= seen_pps_d;
        sticky_q         <= sticky_d;
      end
    end
  end

endmodule

@@ rtl/avcc_burst.sv @@
// Burst sequencer and output register: expands one descriptor into 1..5 results.
// Depends on avcc_pkg.
module avcc_burst (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  avcc_pkg::burst_desc_t desc_i,
  output logic                  free_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output avcc_pkg::result_t     out_o
);

  logic                        bvalid_q, bvalid_d;
  avcc_pkg::burst_desc_t       desc_q;
  logic [avcc_pkg::CNT_W-1:0]  idx_q, idx_d;
  logic                        ovalid_q, ovalid_d;
  avcc_pkg::result_t           res_q;
  avcc_pkg::result_t           item;

  logic [avcc_pkg::CNT_W-1:0]  n_stream;
  logic [avcc_pkg::CNT_W-1:0]  n_total;
  logic                        advance;
  logic                        item_last;

  always_comb begin
    if (desc_q.start_code) begin
      n_stream = avcc_pkg::CNT_W'(avcc_pkg::START_CODE_BYTES);
    end else if (desc_q.payload) begin
      n_stream = avcc_pkg::CNT_W'(1);
    end else begin
      n_stream = '0;
    end
  end

  assign n_total   = n_stream + avcc_pkg::CNT_W'(desc_q.report);
  assign item_last = (idx_q == n_total - avcc_pkg::CNT_W'(1));
  assign advance   = bvalid_q && (!ovalid_q || out_ready_i);
  assign free_o    = !bvalid_q || (advance && item_last);

  always_comb begin
    item        = '0;
    item.status = avcc_pkg::STATUS_OK;
    item.last   = item_last;
    if (idx_q < n_stream) begin
      item.kind = avcc_pkg::KIND_STREAM;
      if (desc_q.start_code) begin
        item.out_byte = (idx_q == n_stream - avcc_pkg::CNT_W'(1)) ?
                        avcc_pkg::SC_LAST_BYTE : avcc_pkg::SC_ZERO_BYTE;
      end else begin
        item.out_byte   = desc_q.data;
        item.nal_header = desc_q.nal_header;
        item.unit_type  = desc_q.unit_type;
      end
    end else begin
      item.kind           = avcc_pkg::KIND_REPORT;
      item.has_param_sets = desc_q.has_param_sets;
      item.status         = desc_q.status;
    end
  end

  always_comb begin
    bvalid_d = bvalid_q;
    idx_d    = idx_q;
    ovalid_d = ovalid_q;
    if (out_ready_i) ovalid_d = 1'b0;
    if (advance) begin
      ovalid_d = 1'b1;
      idx_d    = idx_q + avcc_pkg::CNT_W'(1);
      if (item_last) bvalid_d = 1'b0;
    end
    if (load_i) begin
      bvalid_d = 1'b1;
      idx_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvalid_q <= 1'b0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      bvalid_q <= bvalid_d;
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) desc_q <= desc_i;
    if (advance) res_q <= item;
  end

  assign out_valid_o = ovalid_q;
  assign out_o       = res_q;

endmodule

@@ rtl/avcc_to_annexb_converter_top.sv @@
// Length-prefixed (AVCC) to start-code (Annex B) H.264 converter, top level.
// The first result of a byte passes the descriptor register, then the output register.
// Throughput: one result per cycle while m_tready_i allows; a byte holds the input until
//   the last of its results (1 payload, 4 start code, +1 report) is registered; one without results does not.
// Reset (rst_ni low, async): stream state cleared, length_size set to 4.
// Depends on avcc_pkg, avcc_parse and avcc_burst.
module avcc_to_annexb_converter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: length prefix size in bytes
  input  logic        length_size_we_i,
  input  logic [2:0]  length_size_i,
  // input stream
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,   // [7:0] in_byte
  input  logic        s_tlast_i,   // buffer_end
  // result stream
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  // [7:0] out_byte, [8] nal_header, [13:9] unit_type, [14] has_param_sets,
  // [16:15] status, [23:17] zero
  output logic [23:0] m_tdata_o,
  output logic        m_tuser_o,   // [0] kind
  output logic        m_tlast_o    // last
);

  logic                  s_fire;
  logic                  burst_free;
  logic                  desc_valid;
  avcc_pkg::burst_desc_t desc;
  avcc_pkg::result_t     res;

  // Accept a request whenever the burst stage is free or empties this cycle.
  assign s_tready_o = burst_free;
  assign s_fire     = s_tvalid_i && burst_free;

  // Parse the byte and advance stream state at acceptance.
  avcc_parse u_parse (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .length_size_we_i (length_size_we_i),
    .length_size_i    (length_size_i),
    .fire_i           (s_fire),
    .in_byte_i        (s_tdata_i),
    .buffer_end_i     (s_tlast_i),
    .desc_o           (desc),
    .desc_valid_o     (desc_valid)
  );

  // Hold the descriptor and drain its results through the output register;
  // drop bytes that cause no result.
  avcc_burst u_burst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s_fire && desc_valid),
    .desc_i      (desc),
    .free_o      (burst_free),
    .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i),
    .out_o       (res)
  );

  assign m_tdata_o = {7'd0, res.status, res.has_param_sets, res.unit_type,
                      res.nal_header, res.out_byte};
  assign m_tuser_o = res.kind;
  assign m_tlast_o = res.last;

endmodule
